FILE: sv/wto_pkg.sv
// Shared types and constants for the wavetable crossfade oscillator.
// Used by wto_csr, wto_table and wavetable_oscillator_crossfade; no dependencies.
package wto_pkg;

   // Table geometry: two tables of 2048 entries share one memory
   localparam int IDX_BITS    = 11;
   localparam int ADDR_BITS   = IDX_BITS + 1;
   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS   = 16;
   localparam int PHASE_BITS  = 32;
   localparam int INC_BITS    = 31;
   localparam int LEN_BITS    = 12;
   localparam int CNT_BITS    = 4;

   // Input transaction modes
   localparam logic [1:0] MODE_TICK   = 2'd0;
   localparam logic [1:0] MODE_WRITE  = 2'd1;
   localparam logic [1:0] MODE_COMMIT = 2'd2;

   // Register indexes (word address bit)
   localparam logic REG_PHASE_INC = 1'b0;
   localparam logic REG_XFADE_LEN = 1'b1;

   localparam logic [INC_BITS-1:0] PHASE_INC_RESET = 31'd7158279;
   localparam logic [LEN_BITS-1:0] XFADE_LEN_RESET = 12'd500;

   typedef struct packed {
      logic [1:0]                    mode;
      logic [IDX_BITS-1:0]           write_index;
      logic signed [SAMPLE_BITS-1:0] write_value;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          fading;
   } rsp_type;

   typedef struct packed {
      logic [INC_BITS-1:0] phase_increment;
      logic [LEN_BITS-1:0] crossfade_length;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_A,
      ST_RD_B,
      ST_DIFF,
      ST_MUL,
      ST_INTERP,
      ST_MUL_OLD,
      ST_MUL_NEW,
      ST_ACCUM,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

FILE: sv/wavetable_oscillator_crossfade.sv
// Top level of the double-buffered wavetable oscillator with linear crossfade.
// Depends on wto_pkg, wto_csr and wto_table.
//
// Usage: each req_ transaction carries a mode. A write transaction stores a Q1.15
// value in the inactive table and a commit transaction marks a swap as pending;
// both return nothing. A tick transaction returns one sample
// on the rsp_ channel. The csr port (psel/penable/pwrite/paddr/pwdata) holds the
// phase increment at 0x0 and the crossfade length at 0x4; write it only when idle.
// A tick interpolates between two neighboring entries; during a crossfade it does so in each
// table and then forms the weighted sum and divides, but skips these when the fade count is at
// or above the length. Both table entries come through the single memory read port one at a
// time, one shared 17x17 multiplier forms every product, and the division by the crossfade
// length runs one quotient bit per cycle. req_ready is high only while the sequencer is idle, so
// a tick holds the block until its result is loaded; write and commit transactions are taken
// every cycle while it is idle. Reset: a clearing pass writes zero to all 4096 table entries,
// one per cycle, and req_ready stays low until it ends; the csr port works throughout.
// Stall: the result waits in an output register while rsp_ready is low; further
// write and commit transactions are still taken, and the next tick runs until
// its result must be loaded, then holds there.
module wavetable_oscillator_crossfade (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  wto_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output wto_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam int SB = wto_pkg::SAMPLE_BITS;
   localparam int LB = wto_pkg::LEN_BITS;
   localparam int IB = wto_pkg::IDX_BITS;
   localparam int AB = wto_pkg::ADDR_BITS;
   localparam int FB = wto_pkg::FRAC_BITS;
   localparam int PB = wto_pkg::PHASE_BITS;
   localparam int MB = FB + 1;            // multiplier operand width
   localparam int QB = 2 * MB;            // product width
   localparam int CB = LB + SB + 1;       // crossfade partial sum width
   localparam int UB = LB + SB;           // dividend width

   wto_pkg::cfg_type   cfg;
   wto_pkg::state_type state_ff, state_in;

   logic [AB-1:0]          clr_ff, clr_in;
   logic [PB-1:0]          phase_ff, phase_in;
   logic                   active_ff, active_in;
   logic                   fade_src_ff, fade_src_in;
   logic                   swap_ff, swap_in;
   logic [LB-1:0]          fade_cnt_ff, fade_cnt_in;
   logic                   pass_ff, pass_in;
   logic signed [SB-1:0]   a_ff, a_in;
   logic signed [SB:0]     diff_ff, diff_in;
   logic signed [QB-1:0]   prod_ff, prod_in;
   logic signed [CB-1:0]   acc_ff, acc_in;
   logic signed [SB-1:0]   old_ff, old_in;
   logic signed [SB-1:0]   new_ff, new_in;
   logic [LB-1:0]          rem_ff, rem_in;
   logic [SB-1:0]          quo_ff, quo_in;
   logic [wto_pkg::CNT_BITS-1:0] cnt_ff, cnt_in;
   logic signed [SB-1:0]   res_ff, res_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   wto_pkg::rsp_type       rsp_ff, rsp_in;

   logic                   accept;
   logic                   fading;
   logic                   out_free;
   logic                   sel;
   logic [IB-1:0]          idx;
   logic [IB-1:0]          nxt;
   logic [FB-1:0]          frac;
   logic                   mem_we;
   logic [AB-1:0]          mem_waddr;
   logic signed [SB-1:0]   mem_wdata;
   logic [AB-1:0]          mem_raddr;
   logic signed [SB-1:0]   mem_rdata;
   logic signed [MB-1:0]   mul_a, mul_b;
   logic signed [QB-1:0]   mul_p;
   logic signed [QB-1:0]   round_sum;
   logic signed [SB+2:0]   interp_sum;
   logic signed [SB-1:0]   interp_val;
   logic [LB-1:0]          len_rest;
   logic [UB-1:0]          offset;
   logic signed [UB+1:0]   u_sum;
   logic [LB:0]            trial;
   logic [LB:0]            trial_diff;
   logic                   ge;
   logic [SB-1:0]          quo_next;

   wto_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   wto_table u_table (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // Handshake and phase decode
   assign req_ready = (state_ff == wto_pkg::ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign fading    = (fade_cnt_ff != '0);
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign idx       = phase_ff[PB-1 -: IB];
   assign frac      = phase_ff[PB-IB-1 -: FB];
   assign nxt       = idx + IB'(1);
   assign sel       = (fading && !pass_ff) ? fade_src_ff : active_ff;

   // Memory ports: clearing sweep, or table write into the inactive table
   assign mem_we    = (state_ff == wto_pkg::ST_CLEAR) ||
                      (accept && req_data.mode == wto_pkg::MODE_WRITE);
   assign mem_waddr = (state_ff == wto_pkg::ST_CLEAR) ? clr_ff
                                                     : {~active_ff, req_data.write_index};
   assign mem_wdata = (state_ff == wto_pkg::ST_CLEAR) ? '0 : req_data.write_value;
   assign mem_raddr = {sel, (state_ff == wto_pkg::ST_RD_B) ? nxt : idx};

   // Shared multiplier operand select
   assign len_rest = cfg.crossfade_length - fade_cnt_ff;
   always_comb begin
      case (state_ff)
         wto_pkg::ST_MUL: begin
            mul_a = $signed({1'b0, frac});
            mul_b = diff_ff;
         end
         wto_pkg::ST_MUL_OLD: begin
            mul_a = $signed({{(MB-LB){1'b0}}, fade_cnt_ff});
            mul_b = MB'(old_ff);
         end
         wto_pkg::ST_MUL_NEW: begin
            mul_a = $signed({{(MB-LB){1'b0}}, len_rest});
            mul_b = MB'(new_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // Interpolation: a + floor((f*(b-a) + 2^15) / 2^16)
   assign round_sum  = prod_ff + QB'(32768);
   assign interp_sum = (SB+3)'(a_ff) + (SB+3)'(round_sum[QB-1:FB]);
   assign interp_val = interp_sum[SB-1:0];

   // Crossfade dividend: c*old + (L-c)*new + 2^15*L + L/2
   assign offset = {cfg.crossfade_length, {(SB-1){1'b0}}} +
                   UB'(cfg.crossfade_length[LB-1:1]);
   assign u_sum  = (UB+2)'(acc_ff) + (UB+2)'(prod_ff) + $signed({2'b00, offset});

   // Restoring divide step by the crossfade length
   assign trial      = {rem_ff, quo_ff[SB-1]};
   assign trial_diff = trial - {1'b0, cfg.crossfade_length};
   assign ge         = (trial >= {1'b0, cfg.crossfade_length});
   assign quo_next   = {quo_ff[SB-2:0], ge};

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wto_pkg::ST_CLEAR:   if (clr_ff == '1) state_in = wto_pkg::ST_IDLE;
         wto_pkg::ST_IDLE:    if (accept && req_data.mode == wto_pkg::MODE_TICK) begin
            state_in = wto_pkg::ST_RD_A;
         end
         wto_pkg::ST_RD_A:    state_in = wto_pkg::ST_RD_B;
         wto_pkg::ST_RD_B:    state_in = wto_pkg::ST_DIFF;
         wto_pkg::ST_DIFF:    state_in = wto_pkg::ST_MUL;
         wto_pkg::ST_MUL:     state_in = wto_pkg::ST_INTERP;
         wto_pkg::ST_INTERP: begin
            if (fading && !pass_ff) begin
               state_in = wto_pkg::ST_RD_A;
            end else if (fading && fade_cnt_ff < cfg.crossfade_length) begin
               state_in = wto_pkg::ST_MUL_OLD;
            end else begin
               state_in = wto_pkg::ST_DONE;
            end
         end
         wto_pkg::ST_MUL_OLD: state_in = wto_pkg::ST_MUL_NEW;
         wto_pkg::ST_MUL_NEW: state_in = wto_pkg::ST_ACCUM;
         wto_pkg::ST_ACCUM:   state_in = wto_pkg::ST_DIV;
         wto_pkg::ST_DIV:     if (cnt_ff == '0) state_in = wto_pkg::ST_DONE;
         wto_pkg::ST_DONE:    if (out_free) state_in = wto_pkg::ST_IDLE;
         default:             state_in = wto_pkg::ST_IDLE;
      endcase
   end

   // Datapath and state updates per sequencer step
   always_comb begin
      clr_in       = clr_ff;
      phase_in     = phase_ff;
      active_in    = active_ff;
      fade_src_in  = fade_src_ff;
      swap_in      = swap_ff;
      fade_cnt_in  = fade_cnt_ff;
      pass_in      = pass_ff;
      a_in         = a_ff;
      diff_in      = diff_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      old_in       = old_ff;
      new_in       = new_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      case (state_ff)
         wto_pkg::ST_CLEAR: begin
            clr_in = clr_ff + AB'(1);
         end
         wto_pkg::ST_IDLE: begin
            // Mark a swap as pending on commit; start a tick on its first pass
            if (accept && req_data.mode == wto_pkg::MODE_COMMIT) swap_in = 1'b1;
            pass_in = 1'b0;
         end
         wto_pkg::ST_RD_B: begin
            a_in = mem_rdata;
         end
         wto_pkg::ST_DIFF: begin
            diff_in = (SB+1)'(mem_rdata) - (SB+1)'(a_ff);
         end
         wto_pkg::ST_MUL, wto_pkg::ST_MUL_OLD: begin
            prod_in = mul_p;
         end
         wto_pkg::ST_INTERP: begin
            // Route the interpolated value by pass
            if (fading && !pass_ff) begin
               old_in  = interp_val;
               pass_in = 1'b1;
            end else if (fading) begin
               new_in = interp_val;
               res_in = old_ff;
            end else begin
               res_in = interp_val;
            end
         end
         wto_pkg::ST_MUL_NEW: begin
            acc_in  = prod_ff[CB-1:0];
            prod_in = mul_p;
         end
         wto_pkg::ST_ACCUM: begin
            rem_in = u_sum[UB-1:SB];
            quo_in = u_sum[SB-1:0];
            cnt_in = '1;
         end
         wto_pkg::ST_DIV: begin
            rem_in = ge ? trial_diff[LB-1:0] : trial[LB-1:0];
            quo_in = quo_next;
            cnt_in = cnt_ff - wto_pkg::CNT_BITS'(1);
            if (cnt_ff == '0) res_in = {~quo_next[SB-1], quo_next[SB-2:0]};
         end
         wto_pkg::ST_DONE: begin
            // Load the result, advance the phase, run the fade or start a swap
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_in.sample = res_ff;
               rsp_in.fading = fading;
               phase_in      = phase_ff + PB'(cfg.phase_increment);
               if (fading) begin
                  fade_cnt_in = fade_cnt_ff - LB'(1);
               end else if (swap_ff) begin
                  fade_src_in = active_ff;
                  active_in   = ~active_ff;
                  fade_cnt_in = cfg.crossfade_length;
                  swap_in     = 1'b0;
               end
            end
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wto_pkg::ST_CLEAR;
         clr_ff       <= '0;
         phase_ff     <= '0;
         active_ff    <= 1'b0;
         fade_src_ff  <= 1'b0;
         swap_ff      <= 1'b0;
         fade_cnt_ff  <= '0;
         pass_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         phase_ff     <= phase_in;
         active_ff    <= active_in;
         fade_src_ff  <= fade_src_in;
         swap_ff      <= swap_in;
         fade_cnt_ff  <= fade_cnt_in;
         pass_ff      <= pass_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      diff_ff <= diff_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      old_ff  <= old_in;
      new_ff  <= new_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: sv/wto_csr.sv
// Configuration registers of the wavetable crossfade oscillator on an APB-style port.
// Depends on wto_pkg for the register indexes, reset values and cfg_type.
module wto_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready,
   output wto_pkg::cfg_type    cfg
);

   logic [wto_pkg::INC_BITS-1:0] inc_ff, inc_in;
   logic [wto_pkg::LEN_BITS-1:0] len_ff, len_in;
   logic                         wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;

   // Decode the write transaction
   always_comb begin
      inc_in = inc_ff;
      len_in = len_ff;
      if (wr_en) begin
         case (paddr[2])
            wto_pkg::REG_PHASE_INC: inc_in = pwdata[wto_pkg::INC_BITS-1:0];
            wto_pkg::REG_XFADE_LEN: len_in = pwdata[wto_pkg::LEN_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inc_ff <= wto_pkg::PHASE_INC_RESET;
         len_ff <= wto_pkg::XFADE_LEN_RESET;
      end else begin
         inc_ff <= inc_in;
         len_ff <= len_in;
      end
   end

   // Return the addressed register
   always_comb begin
      case (paddr[2])
         wto_pkg::REG_PHASE_INC: prdata = {1'b0, inc_ff};
         wto_pkg::REG_XFADE_LEN: prdata = {20'd0, len_ff};
         default:                prdata = 32'd0;
      endcase
   end

   assign cfg.phase_increment  = inc_ff;
   assign cfg.crossfade_length = len_ff;

endmodule

FILE: sv/wto_table.sv
// Wave table memory: both tables in one array, one write and one registered read port.
// Depends on wto_pkg for address and sample widths.
module wto_table (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [wto_pkg::ADDR_BITS-1:0]       wr_addr,
   input  logic signed [wto_pkg::SAMPLE_BITS-1:0] wr_data,
   input  logic [wto_pkg::ADDR_BITS-1:0]       rd_addr,
   output logic signed [wto_pkg::SAMPLE_BITS-1:0] rd_data
);

   logic signed [wto_pkg::SAMPLE_BITS-1:0] mem [2**wto_pkg::ADDR_BITS];
   logic signed [wto_pkg::SAMPLE_BITS-1:0] rd_data_ff;

   // Write the entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read every cycle, data registered for the next cycle
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: dv/tb_wavetable_oscillator_crossfade.sv
// Self-checking testbench for the double-buffered wavetable crossfade oscillator.
// Drives wavetable_oscillator_crossfade through its req_/rsp_ channels and APB port, and
// checks every sample against a behavioral predictor or typed row. Depends on wto_pkg.
module tb_wavetable_oscillator_crossfade;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int QUIET_CYCLES = 40;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASE_ITEMS = 200;
   localparam int PRINT_CAP = 100;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   wto_pkg::req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   wto_pkg::rsp_type rsp_data;
   logic psel;
   logic penable;
   logic pwrite;
   logic [2:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   wavetable_oscillator_crossfade DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // Oscillator state mirrored by the predictor
   logic signed [wto_pkg::SAMPLE_BITS-1:0] wave_mem [2][1 << wto_pkg::IDX_BITS];
   logic [wto_pkg::PHASE_BITS-1:0] phase_acc;
   logic active_sel;
   logic fade_src;
   logic [wto_pkg::LEN_BITS-1:0] fade_cnt;
   logic swap_pend;
   logic [wto_pkg::INC_BITS-1:0] pred_inc;
   logic [wto_pkg::LEN_BITS-1:0] pred_len;

   wto_pkg::rsp_type sample_q [$];

   typedef struct {
      wto_pkg::req_type item;
      bit typed;
      wto_pkg::rsp_type want;
   } dir_row_type;
   dir_row_type dir_rows [$];

   // Typed expectation for the transaction currently offered
   bit use_typed;
   wto_pkg::rsp_type typed_want;

   int send_idle_pct;
   int recv_stall_pct;
   int hold_asks;
   int mismatch_count;
   int checked_count;
   int fading_count;
   int sent_count;
   int config_count;
   int cycle_count;

   function automatic longint clamp16(input longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // Linear interpolation between neighboring entries; >>> floors a signed value
   function automatic longint interp(input logic sel,
                                     input logic [wto_pkg::IDX_BITS-1:0] i,
                                     input logic [wto_pkg::IDX_BITS-1:0] n, input longint f);
      longint a, b, x;
      a = wave_mem[sel][i];
      b = wave_mem[sel][n];
      x = f * (b - a) + 32768;
      return clamp16(a + (x >>> 16));
   endfunction

   // Advance the predicted oscillator by one transaction
   task automatic osc_step(input wto_pkg::req_type it, output bit produced,
                           output wto_pkg::rsp_type res);
      logic [wto_pkg::IDX_BITS-1:0] idx, nxt;
      longint frac, oldv, newv, c, len, num, s;
      produced = 1'b0;
      res = '0;
      case (it.mode)
         wto_pkg::MODE_WRITE: wave_mem[~active_sel][it.write_index] = it.write_value;
         wto_pkg::MODE_COMMIT: swap_pend = 1'b1;
         wto_pkg::MODE_TICK: begin
            produced = 1'b1;
            idx = phase_acc[31:21];
            nxt = idx + 1'b1;
            frac = phase_acc[20:5];
            if (fade_cnt != 0) begin
               oldv = interp(fade_src, idx, nxt, frac);
               newv = interp(active_sel, idx, nxt, frac);
               len = pred_len;
               c = fade_cnt;
               if (c >= len) begin
                  s = oldv;
               end else begin
                  num = c * oldv + (len - c) * newv + 32768 * len + len / 2;
                  s = clamp16(num / len - 32768);
               end
               res.fading = 1'b1;
               fade_cnt = fade_cnt - 1'b1;
            end else begin
               s = interp(active_sel, idx, nxt, frac);
               if (swap_pend) begin
                  fade_src = active_sel;
                  active_sel = ~active_sel;
                  fade_cnt = pred_len;
                  swap_pend = 1'b0;
               end
            end
            res.sample = s[wto_pkg::SAMPLE_BITS-1:0];
            phase_acc = phase_acc + {1'b0, pred_inc};
         end
         default: ;
      endcase
   endtask

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Abort a hung run
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d samples outstanding",
                  cycle_count, sample_q.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // Receiver: random stalls, plus long hold-offs on request
   initial begin : receiver
      int hold_seen;
      int hold_left;
      hold_seen = 0;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Predict on accepted requests, check accepted results
   always @(posedge clock) begin
      bit produced;
      wto_pkg::rsp_type res;
      wto_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            osc_step(req_data, produced, res);
            if (produced) sample_q.push_back(use_typed ? typed_want : res);
         end
         if (rsp_valid && rsp_ready) begin
            checked_count++;
            if (rsp_data.fading) fading_count++;
            if (sample_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= PRINT_CAP)
                  $error("unexpected result: sample %0d fading %0b",
                         rsp_data.sample, rsp_data.fading);
            end else begin
               want = sample_q.pop_front();
               if (rsp_data.sample !== want.sample) begin
                  mismatch_count++;
                  if (mismatch_count <= PRINT_CAP)
                     $error("sample: expected %0d, actual %0d", want.sample, rsp_data.sample);
               end
               if (rsp_data.fading !== want.fading) begin
                  mismatch_count++;
                  if (mismatch_count <= PRINT_CAP)
                     $error("fading: expected %0b, actual %0b", want.fading, rsp_data.fading);
               end
            end
         end
      end
   end

   // Offer one transaction and hold it until accepted; enter and leave at a falling edge
   task automatic push_req(input wto_pkg::req_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
      @(negedge clock);
   endtask

   // One APB transfer; psel is dropped before the task returns, so the bus goes idle between transfers
   task automatic csr_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= addr;
      pwdata <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rdata = prdata;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
   endtask

   task automatic csr_check(input logic [2:0] addr, input logic [31:0] want, input string name);
      logic [31:0] got;
      csr_access(1'b0, addr, '0, got);
      if (got !== want) begin
         mismatch_count++;
         $error("%s: expected %0d, actual %0d", name, want, got);
      end
   endtask

   // Drain the pipeline, let the sequencer settle, then load and check both registers
   task automatic apply_config(input logic [wto_pkg::INC_BITS-1:0] inc,
                               input logic [wto_pkg::LEN_BITS-1:0] len);
      logic [31:0] unused;
      logic [2:0] inc_addr, len_addr;
      inc_addr = {wto_pkg::REG_PHASE_INC, 2'b00};
      len_addr = {wto_pkg::REG_XFADE_LEN, 2'b00};
      req_valid <= 1'b0;
      while (sample_q.size() != 0) @(negedge clock);
      repeat (QUIET_CYCLES) @(negedge clock);
      csr_access(1'b1, inc_addr, {1'b0, inc}, unused);
      pred_inc = inc;
      csr_access(1'b1, len_addr, {20'd0, len}, unused);
      pred_len = len;
      csr_check(inc_addr, {1'b0, inc}, "phase_increment");
      csr_check(len_addr, {20'd0, len}, "crossfade_length");
      config_count++;
   endtask

   function automatic void add_row(input logic [1:0] mode, input int idx, input int val,
                                   input bit typed = 1'b0, input int smp = 0,
                                   input bit fad = 1'b0);
      dir_row_type row;
      row.item.mode = mode;
      row.item.write_index = wto_pkg::IDX_BITS'(idx);
      row.item.write_value = wto_pkg::SAMPLE_BITS'(val);
      row.typed = typed;
      row.want.sample = wto_pkg::SAMPLE_BITS'(smp);
      row.want.fading = fad;
      dir_rows.push_back(row);
   endfunction

   // Mostly ticks and writes near the upcoming read position, some commits and noise
   function automatic wto_pkg::req_type make_item();
      wto_pkg::req_type it;
      int r;
      r = $urandom_range(99);
      it.write_index = wto_pkg::IDX_BITS'($urandom);
      it.write_value = wto_pkg::SAMPLE_BITS'($urandom);
      if (r < 55) begin
         it.mode = wto_pkg::MODE_TICK;
      end else if (r < 88) begin
         it.mode = wto_pkg::MODE_WRITE;
         if ($urandom_range(99) < 70)
            it.write_index = phase_acc[31:21] + wto_pkg::IDX_BITS'($urandom_range(40));
         case ($urandom_range(9))
            0: it.write_value = 16'sh7FFF;
            1: it.write_value = 16'sh8000;
            2: it.write_value = 16'sh0000;
            3: it.write_value = 16'shFFFF;
            default: ;
         endcase
      end else if (r < 94) begin
         it.mode = wto_pkg::MODE_COMMIT;
      end else begin
         it.mode = MODE_UNUSED;
      end
      return it;
   endfunction

   initial begin : stimulus
      logic [wto_pkg::INC_BITS-1:0] inc;
      logic [wto_pkg::LEN_BITS-1:0] len;
      int n;
      req_valid = 1'b0;
      req_data = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      use_typed = 1'b0;
      typed_want = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_asks = 0;
      mismatch_count = 0;
      checked_count = 0;
      fading_count = 0;
      sent_count = 0;
      config_count = 0;
      foreach (wave_mem[s, i]) wave_mem[s][i] = '0;
      phase_acc = '0;
      active_sel = 1'b0;
      fade_src = 1'b0;
      fade_cnt = '0;
      swap_pend = 1'b0;
      pred_inc = wto_pkg::PHASE_INC_RESET;
      pred_len = wto_pkg::XFADE_LEN_RESET;

      // Hold reset, then release it
      reset = 1'b1;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Registers come up at their reset values
      csr_check({wto_pkg::REG_PHASE_INC, 2'b00}, {1'b0, wto_pkg::PHASE_INC_RESET},
                "phase_increment");
      csr_check({wto_pkg::REG_XFADE_LEN, 2'b00}, {20'd0, wto_pkg::XFADE_LEN_RESET},
                "crossfade_length");

      // Directed part: one entry per tick with zero fraction, four-sample fade
      add_row(wto_pkg::MODE_TICK, 0, 0, 1'b1, 0, 1'b0);
      add_row(MODE_UNUSED, 2047, -1);
      add_row(wto_pkg::MODE_WRITE, 0, 32767);
      add_row(wto_pkg::MODE_WRITE, 1, -32768);
      add_row(wto_pkg::MODE_WRITE, 2047, -1);
      add_row(wto_pkg::MODE_WRITE, 2, 16384);
      add_row(wto_pkg::MODE_WRITE, 4, 20000);
      add_row(wto_pkg::MODE_WRITE, 5, -20000);
      add_row(wto_pkg::MODE_TICK, 0, 0, 1'b1, 0, 1'b0);
      add_row(wto_pkg::MODE_COMMIT, 0, 0);
      add_row(wto_pkg::MODE_TICK, 0, 0, 1'b1, 0, 1'b0);
      // fade count equal to the length: old table alone
      add_row(wto_pkg::MODE_TICK, 0, 0, 1'b1, 0, 1'b1);
      add_row(wto_pkg::MODE_TICK, 0, 0);
      // commit during the fade stays pending; the write lands in the fading table
      add_row(wto_pkg::MODE_COMMIT, 0, 0);
      add_row(wto_pkg::MODE_WRITE, 6, 12345);
      add_row(wto_pkg::MODE_TICK, 0, 0);
      add_row(wto_pkg::MODE_TICK, 0, 0);
      add_row(wto_pkg::MODE_TICK, 0, 0);
      add_row(wto_pkg::MODE_TICK, 0, 0);
      add_row(wto_pkg::MODE_TICK, 0, 0);

      apply_config(wto_pkg::INC_BITS'(1) << 21, 12'd4);
      foreach (dir_rows[i]) begin
         use_typed = dir_rows[i].typed;
         typed_want = dir_rows[i].want;
         push_req(dir_rows[i].item);
      end
      use_typed = 1'b0;

      // Random phases, each with its own setting; the idling patterns repeat every four phases
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: begin inc = '0; len = 12'd64; end
            1: begin inc = wto_pkg::PHASE_INC_RESET; len = 12'd1; end
            2: begin inc = '1; len = 12'd0; end
            3: begin
               inc = wto_pkg::INC_BITS'($urandom);
               len = wto_pkg::LEN_BITS'($urandom_range(1, 64));
            end
            4: begin
               inc = wto_pkg::INC_BITS'($urandom_range(1 << 16, 1 << 22));
               len = wto_pkg::LEN_BITS'($urandom_range(1, 64));
            end
            5: begin
               inc = wto_pkg::INC_BITS'($urandom);
               len = wto_pkg::LEN_BITS'($urandom_range(1, 300));
            end
            6: begin
               inc = wto_pkg::INC_BITS'($urandom_range(0, 1 << 20));
               len = wto_pkg::LEN_BITS'($urandom_range(1, 16));
            end
            default: begin inc = wto_pkg::PHASE_INC_RESET; len = 12'd4095; end
         endcase
         apply_config(inc, len);
         case (p % 4)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 53; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 53; end
            default: begin send_idle_pct = 35; recv_stall_pct = 35; end
         endcase
         n = 0;
         while (n < PHASE_ITEMS) begin
            req_data_gen : begin
               wto_pkg::req_type it;
               it = make_item();
               n++;
               push_req(it);
            end
            // Stall the receiver long enough to back up the input
            if (p == 2 && n == 50) hold_asks++;
            // Pause the sender until every sample is back
            if (p == 4 && n == 100) begin
               req_valid <= 1'b0;
               while (sample_q.size() != 0) @(negedge clock);
            end
         end
         send_idle_pct = 0;
         recv_stall_pct = 0;
      end

      // Drain and let the block settle
      req_valid <= 1'b0;
      while (sample_q.size() != 0) @(negedge clock);
      repeat (QUIET_CYCLES) @(negedge clock);

      $display("Sent %0d transactions over %0d register settings; checked %0d samples",
               sent_count, config_count, checked_count);
      $display("%0d samples came from crossfades; %0d mismatches", fading_count,
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: wavetable_oscillator_crossfade.f
sv/wto_pkg.sv
sv/wto_csr.sv
sv/wto_table.sv
sv/wavetable_oscillator_crossfade.sv
dv/tb_wavetable_oscillator_crossfade.sv
